// File: hdl/irqt_pkg.sv
// shared types, codes and helpers for the quarter-turn image rotation block
// no dependencies
`timescale 1ns / 1ps

package irqt_pkg;

  localparam int unsigned MaxSide      = 256;
  localparam int unsigned MaxComps     = 4;
  localparam int unsigned SideW        = 9;   // 1..256
  localparam int unsigned CoordW       = 8;   // 0..255
  localparam int unsigned AddrW        = 16;  // frame store depth 65536
  localparam int unsigned PosW         = 17;  // 0..65536
  localparam int unsigned CompCntW     = 3;
  localparam int unsigned TurnsW       = 2;
  localparam int unsigned WordW        = 32;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned CfgDataW     = 9;
  localparam int unsigned FifoDepth    = 4;
  localparam int unsigned FifoPtrW     = 2;
  localparam int unsigned FifoCntW     = 3;

  // command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EMIT = 1'b1;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_COMPS  = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_TURNS  = 2'd3;

  // settings as seen by the datapath, already clamped
  typedef struct packed {
    logic [SideW-1:0]    width;
    logic [SideW-1:0]    height;
    logic [CompCntW-1:0] comps;
    logic [TurnsW-1:0]   turns;
    logic [PosW-1:0]     total;
  } cfg_t;

  // one queued store operation
  typedef struct packed {
    logic             emit;
    logic [AddrW-1:0] addr;
    logic [WordW-1:0] data;
    logic             last;
  } op_t;

  function automatic logic [SideW-1:0] clamp_side(input logic [SideW-1:0] v);
    logic [SideW-1:0] r;
    r = v;
    if (v == '0) begin
      r = SideW'(1);
    end else if (v > SideW'(MaxSide)) begin
      r = SideW'(MaxSide);
    end
    return r;
  endfunction

  function automatic logic [CompCntW-1:0] clamp_comps(input logic [CompCntW-1:0] v);
    logic [CompCntW-1:0] r;
    r = v;
    if (v == '0) begin
      r = CompCntW'(1);
    end else if (v > CompCntW'(MaxComps)) begin
      r = CompCntW'(MaxComps);
    end
    return r;
  endfunction

endpackage

// File: hdl/irqt_front.sv
// front end: accepts words, tracks load and output positions, builds store ops
// depends on irqt_pkg
`timescale 1ns / 1ps

module irqt_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  irqt_pkg::cfg_t             cfg_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       command_i,
  input  logic [7:0]                 comp_a_i,
  input  logic [7:0]                 comp_b_i,
  input  logic [7:0]                 comp_c_i,
  input  logic [7:0]                 comp_d_i,
  input  logic                       q_full_i,
  output logic                       q_push_o,
  output irqt_pkg::op_t              q_op_o
);

  logic [irqt_pkg::PosW-1:0]   load_pos_q, load_pos_d;
  logic [irqt_pkg::CoordW-1:0] col_q, col_d, row_q, row_d;

  logic                        accept;
  logic                        load_ok;
  logic [irqt_pkg::SideW-1:0]  ow, oh;
  logic [irqt_pkg::SideW-1:0]  c9, r9, x9, y9;
  logic [irqt_pkg::CoordW-1:0] c, r;
  logic [16:0]                 prod;
  logic [irqt_pkg::AddrW-1:0]  emit_addr;
  logic                        last;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign load_ok    = load_pos_q < cfg_i.total;

  always_comb begin
    ow = cfg_i.turns[0] ? cfg_i.height : cfg_i.width;
    oh = cfg_i.turns[0] ? cfg_i.width  : cfg_i.height;

    // restart when the position fell outside the current output size
    if ({1'b0, col_q} >= ow || {1'b0, row_q} >= oh) begin
      c = '0;
      r = '0;
    end else begin
      c = col_q;
      r = row_q;
    end
    c9 = {1'b0, c};
    r9 = {1'b0, r};

    case (cfg_i.turns)
      2'd0: begin
        x9 = c9;
        y9 = r9;
      end
      2'd1: begin
        x9 = r9;
        y9 = cfg_i.height - 9'd1 - c9;
      end
      2'd2: begin
        x9 = cfg_i.width - 9'd1 - c9;
        y9 = cfg_i.height - 9'd1 - r9;
      end
      default: begin
        x9 = cfg_i.width - 9'd1 - r9;
        y9 = c9;
      end
    endcase

    prod      = {9'b0, y9[7:0]} * {8'b0, cfg_i.width};
    emit_addr = prod[15:0] + {8'b0, x9[7:0]};
    last      = (c9 == ow - 9'd1) && (r9 == oh - 9'd1);
  end

  always_comb begin
    load_pos_d = load_pos_q;
    col_d      = col_q;
    row_d      = row_q;
    q_push_o   = 1'b0;
    q_op_o.emit = command_i;
    q_op_o.data = {comp_d_i, comp_c_i, comp_b_i, comp_a_i};
    q_op_o.last = last;
    q_op_o.addr = (command_i == irqt_pkg::CMD_EMIT) ? emit_addr
                                                    : load_pos_q[irqt_pkg::AddrW-1:0];
    if (accept) begin
      if (command_i == irqt_pkg::CMD_EMIT) begin
        q_push_o = 1'b1;
        if (c9 + 9'd1 < ow) begin
          col_d = c + 8'd1;
          row_d = r;
        end else begin
          col_d = '0;
          row_d = (r9 + 9'd1 < oh) ? r + 8'd1 : '0;
        end
      end else if (load_ok) begin
        // loads past the end of the frame are dropped
        q_push_o   = 1'b1;
        load_pos_d = load_pos_q + 17'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_pos_q <= '0;
      col_q      <= '0;
      row_q      <= '0;
    end else begin
      load_pos_q <= load_pos_d;
      col_q      <= col_d;
      row_q      <= row_d;
    end
  end

endmodule

// File: hdl/irqt_fifo.sv
// short op queue between front end and back end
// depends on irqt_pkg
`timescale 1ns / 1ps

module irqt_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  irqt_pkg::op_t op_i,
  output logic          full_o,
  input  logic          pop_i,
  output irqt_pkg::op_t head_o,
  output logic          empty_o
);

  irqt_pkg::op_t                 slots_q [irqt_pkg::FifoDepth];
  logic [irqt_pkg::FifoPtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [irqt_pkg::FifoCntW-1:0] count_q, count_d;

  assign full_o  = count_q == irqt_pkg::FifoCntW'(irqt_pkg::FifoDepth);
  assign empty_o = count_q == '0;
  assign head_o  = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 2'd1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 2'd1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 3'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// File: hdl/irqt_back.sv
// back end: frame store, executes queued loads and emits, output register
// depends on irqt_pkg
`timescale 1ns / 1ps

module irqt_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  irqt_pkg::cfg_t cfg_i,
  input  irqt_pkg::op_t head_i,
  input  logic          empty_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [7:0]    out_a_o,
  output logic [7:0]    out_b_o,
  output logic [7:0]    out_c_o,
  output logic [7:0]    out_d_o,
  output logic          last_pixel_o
);

  localparam int unsigned MemDepth = irqt_pkg::MaxSide * irqt_pkg::MaxSide;

  logic [irqt_pkg::WordW-1:0] store_mem [MemDepth];
  logic [irqt_pkg::WordW-1:0] rd_data_q;
  logic                       out_valid_q, out_valid_d;
  logic                       last_q;
  logic                       out_free;
  logic                       do_load, do_read;

  // the read register doubles as the output register, so it only moves when free
  assign out_free = !out_valid_q || !out_stall_i;
  assign do_load  = !empty_i && !head_i.emit;
  assign do_read  = !empty_i && head_i.emit && out_free;
  assign pop_o    = do_load || do_read;

  always_comb begin
    out_valid_d = out_valid_q;
    if (do_read) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_load) begin
      store_mem[head_i.addr] <= head_i.data;
    end
    if (do_read) begin
      rd_data_q <= store_mem[head_i.addr];
      last_q    <= head_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign last_pixel_o = last_q;
  assign out_a_o      = rd_data_q[7:0];
  assign out_b_o      = (cfg_i.comps > 3'd1) ? rd_data_q[15:8]  : 8'd0;
  assign out_c_o      = (cfg_i.comps > 3'd2) ? rd_data_q[23:16] : 8'd0;
  assign out_d_o      = (cfg_i.comps > 3'd3) ? rd_data_q[31:24] : 8'd0;

endmodule

// File: hdl/image_rotate_quarter_turns.sv
// Quarter-turn image rotation engine, clockwise.
// Input channel (in_valid_i / in_stall_o): each word is a command. A load
// writes comp_a..comp_d to the next raster slot of a 64K-pixel frame store;
// loads past width*height are dropped. An emit returns the next pixel of the
// rotated image in output raster order, last_pixel_o marks the final one, and
// the position wraps to the start afterwards.
// Output channel (out_valid_o / out_stall_i): one word per emit; unused
// components read as zero.
// Config port: cfg_we_i writes cfg_data_i into register cfg_index_i (width,
// height, component count, quarter turns); write only while the block is idle.
// A new setting applies to the very next word; an emit may follow a load
// directly, the queue keeps them in order.
// Path: an accepted emit is queued, then its store read is registered in the
// output register. One word per cycle is sustained while the output is not
// stalled; the single-port frame store takes one access per cycle.
// A four-entry queue separates the front end from the store.
// Reset clears positions and settings (1x1 image, 4 components, no turn); the
// frame store is not cleared. When the receiver stalls the output holds, queued
// words drain up to the first waiting emit, and the input stalls once the queue
// fills. Depends on irqt_pkg, irqt_front, irqt_fifo, irqt_back
`timescale 1ns / 1ps

module image_rotate_quarter_turns (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [irqt_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [irqt_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            command_i,
  input  logic [7:0]                      comp_a_i,
  input  logic [7:0]                      comp_b_i,
  input  logic [7:0]                      comp_c_i,
  input  logic [7:0]                      comp_d_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [7:0]                      out_a_o,
  output logic [7:0]                      out_b_o,
  output logic [7:0]                      out_c_o,
  output logic [7:0]                      out_d_o,
  output logic                            last_pixel_o
);

  logic [irqt_pkg::SideW-1:0]    width_q, height_q;
  logic [irqt_pkg::CompCntW-1:0] comps_q;
  logic [irqt_pkg::TurnsW-1:0]   turns_q;
  logic [17:0]                   area;
  irqt_pkg::cfg_t                cfg;

  logic          q_push, q_full, q_pop, q_empty;
  irqt_pkg::op_t q_op, q_head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= irqt_pkg::SideW'(1);
      height_q <= irqt_pkg::SideW'(1);
      comps_q  <= irqt_pkg::CompCntW'(4);
      turns_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        irqt_pkg::REG_WIDTH:  width_q  <= cfg_data_i;
        irqt_pkg::REG_HEIGHT: height_q <= cfg_data_i;
        irqt_pkg::REG_COMPS:  comps_q  <= cfg_data_i[irqt_pkg::CompCntW-1:0];
        irqt_pkg::REG_TURNS:  turns_q  <= cfg_data_i[irqt_pkg::TurnsW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.width  = irqt_pkg::clamp_side(width_q);
    cfg.height = irqt_pkg::clamp_side(height_q);
    cfg.comps  = irqt_pkg::clamp_comps(comps_q);
    cfg.turns  = turns_q;
    area       = {9'b0, cfg.width} * {9'b0, cfg.height};
    cfg.total  = area[irqt_pkg::PosW-1:0];
  end

  irqt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .comp_a_i   (comp_a_i),
    .comp_b_i   (comp_b_i),
    .comp_c_i   (comp_c_i),
    .comp_d_i   (comp_d_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_op_o     (q_op)
  );

  irqt_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .op_i    (q_op),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .empty_o (q_empty)
  );

  irqt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .head_i       (q_head),
    .empty_i      (q_empty),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_a_o      (out_a_o),
    .out_b_o      (out_b_o),
    .out_c_o      (out_c_o),
    .out_d_o      (out_d_o),
    .last_pixel_o (last_pixel_o)
  );

endmodule
